@@ rtl/emi_pkg.sv @@
// ----------------------------------------------------------------------------
// emi_pkg: shared types and constants of the eased motion interpolator
// register indexes, ease modes, sequencer states and the quarter-wave sine table
// ----------------------------------------------------------------------------
`default_nettype none

package emi_pkg;

   localparam int TIME_BITS_DEFAULT  = 16;
   localparam int SINE_TABLE_ENTRIES = 256;
   localparam int SINE_IDX_BITS      = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int DIV_STEPS          = 17;
   localparam int DIV_CNT_BITS       = $clog2(DIV_STEPS);

   localparam logic [15:0] DURATION_RESET = 16'd1000;
   localparam logic [16:0] Q16_ONE        = 17'h10000;
   localparam logic [16:0] Q16_HALF       = 17'h08000;

   typedef enum logic [2:0] {
      REG_DURATION = 3'd0,
      REG_START_X  = 3'd1,
      REG_START_Y  = 3'd2,
      REG_END_X    = 3'd3,
      REG_END_Y    = 3'd4,
      REG_EASE     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      EASE_LINEAR   = 2'd0,
      EASE_SINE_IN  = 2'd1,
      EASE_SINE_OUT = 2'd2,
      EASE_SINE_IO  = 2'd3
   } ease_mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_PHASE,
      S_EASE,
      S_MUL_X,
      S_MUL_Y,
      S_OUT
   } seq_state_type;

   typedef logic [16:0] sine_lut_type [0:SINE_TABLE_ENTRIES];

   // odd polynomial in q30, rounded to q16 and clamped to one
   function automatic sine_lut_type build_sine_lut();
      sine_lut_type lut;
      logic [63:0]  u;
      logic [63:0]  u2;
      logic [63:0]  t;
      logic [63:0]  v;
      for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
         u  = (64'(i) << 30) / 64'(SINE_TABLE_ENTRIES);
         u2 = (u * u) >> 30;
         t  = 64'd61;
         t  = 64'd3864 - ((t * u2) >> 30);
         t  = 64'd172272 - ((t * u2) >> 30);
         t  = 64'd5026995 - ((t * u2) >> 30);
         t  = 64'd85569306 - ((t * u2) >> 30);
         t  = 64'd693598668 - ((t * u2) >> 30);
         t  = 64'd1686629713 - ((t * u2) >> 30);
         v  = (((t * u) >> 30) + 64'd8192) >> 14;
         lut[i] = (v > 64'h10000) ? Q16_ONE : v[16:0];
      end
      return lut;
   endfunction

   localparam sine_lut_type SINE_LUT = build_sine_lut();

endpackage

`default_nettype wire

@@ rtl/eased_motion_interpolator.sv @@
// ----------------------------------------------------------------------------
// eased_motion_interpolator: eased point between two coordinates over time
// Each req item carries a time step in ms. The step is added to the elapsed
// time, clamped at the duration, and the signed leftover step is reported.
// Progress elapsed/duration (q1.16) comes from a bit-serial restoring divider,
// is shaped by the selected ease curve through a quarter-wave sine table and
// drives one shared multiplier that interpolates x, then y.
// Channels: req (delta_ms in) and rsp (point, leftover and finished flag out),
// both valid/ready; csr is a plain write port that the user must write only
// while idle; the block itself does not enforce it. From req acceptance an
// item goes through the 17 divider steps, phase lookup, ease, two multiplier
// passes and output; a zero duration skips the divider. One item is in work
// at a time: no req item is taken until the last one leaves the sequencer.
// A finished item waits in the rsp register; the next req item is
// taken while it waits, and its result is held in the sequencer until rsp
// drains. Reset clears elapsed time and restores the registers (duration
// 1000 ms, coordinates zero, linear easing); elapsed time is also cleared
// by an item taken at zero duration.
// ----------------------------------------------------------------------------
`default_nettype none

module eased_motion_interpolator #(
   parameter int TIME_BITS = emi_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // delta_ms[15:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // pos_x[15:0], pos_y[31:16],
                                         // leftover_ms[48:32], finished[49], zero
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);

   localparam int WideBits = (TIME_BITS > 16) ? TIME_BITS : 16;
   localparam logic [WideBits-1:0] TimeMax = WideBits'((64'd1 << TIME_BITS) - 64'd1);

   // configuration registers
   logic [15:0]                 duration_ff;
   logic signed [15:0]          start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   emi_pkg::ease_mode_type      ease_ff;

   // sequencer and datapath registers
   emi_pkg::seq_state_type      state_ff, state_in;
   logic [TIME_BITS-1:0]        elapsed_ff, elapsed_in;
   logic [TIME_BITS:0]          rem_ff, rem_in;
   logic [16:0]                 quo_ff, quo_in;
   logic [emi_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [16:0]                 sine_ff, sine_in;
   logic [16:0]                 ease_val_ff, ease_val_in;
   logic signed [34:0]          prod_ff, prod_in;
   logic [15:0]                 pos_x_ff, pos_x_in;
   logic [16:0]                 leftover_ff, leftover_in;
   logic                        finished_ff, finished_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [55:0]                 rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic [WideBits-1:0]         dur_wide;
   logic [TIME_BITS-1:0]        dur_t;
   logic [TIME_BITS-1:0]        el_clamp;
   logic [TIME_BITS-1:0]        remaining;
   logic [WideBits-1:0]         delta_w;
   logic [WideBits-1:0]         rem_w;
   logic                        take_all;
   logic [TIME_BITS-1:0]        elapsed_new;
   logic signed [WideBits:0]    leftover_w;
   logic [TIME_BITS:0]          trial;
   logic                        trial_ge;
   logic [16:0]                 phase;
   logic [31:0]                 idx_prod;
   logic [emi_pkg::SINE_IDX_BITS-1:0] sine_idx;
   logic [17:0]                 half_sum;
   logic signed [16:0]          mul_a;
   logic signed [17:0]          mul_b;
   logic signed [34:0]          rounded;
   logic [15:0]                 pos_cur;
   logic signed [15:0]          start_cur;
   logic                        accept;
   logic                        out_free;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= emi_pkg::DURATION_RESET;
         start_x_ff  <= '0;
         start_y_ff  <= '0;
         end_x_ff    <= '0;
         end_y_ff    <= '0;
         ease_ff     <= emi_pkg::EASE_LINEAR;
      end else if (csr_we) begin
         unique case (csr_addr)
            emi_pkg::REG_DURATION: duration_ff <= csr_wdata;
            emi_pkg::REG_START_X:  start_x_ff  <= csr_wdata;
            emi_pkg::REG_START_Y:  start_y_ff  <= csr_wdata;
            emi_pkg::REG_END_X:    end_x_ff    <= csr_wdata;
            emi_pkg::REG_END_Y:    end_y_ff    <= csr_wdata;
            emi_pkg::REG_EASE:     ease_ff     <= emi_pkg::ease_mode_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   // time bookkeeping for the incoming item
   always_comb begin
      dur_wide    = WideBits'(duration_ff);
      dur_t       = (dur_wide > TimeMax) ? TimeMax[TIME_BITS-1:0]
                                         : dur_wide[TIME_BITS-1:0];
      el_clamp    = (elapsed_ff > dur_t) ? dur_t : elapsed_ff;
      remaining   = dur_t - el_clamp;
      delta_w     = WideBits'(req_tdata);
      rem_w       = WideBits'(remaining);
      take_all    = (delta_w <= rem_w);
      elapsed_new = take_all ? (el_clamp + delta_w[TIME_BITS-1:0]) : dur_t;
      leftover_w  = $signed({1'b0, delta_w}) - $signed({1'b0, rem_w});
   end

   // divider step, phase, table index, ease and shared multiplier
   always_comb begin
      trial    = (cnt_ff == '0) ? rem_ff : {rem_ff[TIME_BITS-1:0], 1'b0};
      trial_ge = (trial >= {1'b0, dur_t});

      case (ease_ff)
         emi_pkg::EASE_SINE_IN:  phase = emi_pkg::Q16_ONE - quo_ff;
         emi_pkg::EASE_SINE_OUT: phase = quo_ff;
         emi_pkg::EASE_SINE_IO:  phase = (quo_ff <= emi_pkg::Q16_HALF)
                                         ? (emi_pkg::Q16_ONE - {quo_ff[15:0], 1'b0})
                                         : ({quo_ff[15:0], 1'b0} - emi_pkg::Q16_ONE);
         default:                phase = quo_ff;
      endcase
      idx_prod = 32'(phase) * 32'(emi_pkg::SINE_TABLE_ENTRIES) + 32'd32768;
      sine_idx = idx_prod[16 +: emi_pkg::SINE_IDX_BITS];

      half_sum = (quo_ff <= emi_pkg::Q16_HALF)
                 ? (18'(emi_pkg::Q16_ONE) - 18'(sine_ff) + 18'd1)
                 : (18'(emi_pkg::Q16_ONE) + 18'(sine_ff) + 18'd1);

      if (state_ff == emi_pkg::S_MUL_X) begin
         mul_a = 17'(end_x_ff) - 17'(start_x_ff);
      end else begin
         mul_a = 17'(end_y_ff) - 17'(start_y_ff);
      end
      mul_b = $signed({1'b0, ease_val_ff});

      start_cur = (state_ff == emi_pkg::S_MUL_Y) ? start_x_ff : start_y_ff;
      rounded   = prod_ff + 35'sd32768;
      pos_cur   = start_cur + rounded[31:16];
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      elapsed_in   = elapsed_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      sine_in      = sine_ff;
      ease_val_in  = ease_val_ff;
      prod_in      = prod_ff;
      pos_x_in     = pos_x_ff;
      leftover_in  = leftover_ff;
      finished_in  = finished_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      req_tready = (state_ff == emi_pkg::S_IDLE);
      accept     = req_tvalid && req_tready;
      out_free   = !rsp_valid_ff || rsp_tready;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         emi_pkg::S_IDLE: begin
            if (accept) begin
               elapsed_in  = elapsed_new;
               leftover_in = leftover_w[16:0];
               finished_in = (elapsed_new == dur_t);
               rem_in      = {1'b0, elapsed_new};
               cnt_in      = '0;
               if (dur_t == '0) begin
                  quo_in   = emi_pkg::Q16_ONE;
                  state_in = emi_pkg::S_PHASE;
               end else begin
                  quo_in   = '0;
                  state_in = emi_pkg::S_DIV;
               end
            end
         end
         emi_pkg::S_DIV: begin
            rem_in = trial_ge ? (trial - {1'b0, dur_t}) : trial;
            quo_in = {quo_ff[15:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == emi_pkg::DIV_CNT_BITS'(emi_pkg::DIV_STEPS - 1)) begin
               state_in = emi_pkg::S_PHASE;
            end
         end
         emi_pkg::S_PHASE: begin
            sine_in  = emi_pkg::SINE_LUT[sine_idx];
            state_in = emi_pkg::S_EASE;
         end
         emi_pkg::S_EASE: begin
            case (ease_ff)
               emi_pkg::EASE_SINE_IN:  ease_val_in = emi_pkg::Q16_ONE - sine_ff;
               emi_pkg::EASE_SINE_OUT: ease_val_in = sine_ff;
               emi_pkg::EASE_SINE_IO:  ease_val_in = half_sum[17:1];
               default:                ease_val_in = quo_ff;
            endcase
            state_in = emi_pkg::S_MUL_X;
         end
         emi_pkg::S_MUL_X: begin
            prod_in  = mul_a * mul_b;
            state_in = emi_pkg::S_MUL_Y;
         end
         emi_pkg::S_MUL_Y: begin
            pos_x_in = pos_cur;
            prod_in  = mul_a * mul_b;
            state_in = emi_pkg::S_OUT;
         end
         emi_pkg::S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, finished_ff, leftover_ff, pos_cur, pos_x_ff};
               state_in     = emi_pkg::S_IDLE;
            end
         end
         default: state_in = emi_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= emi_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      sine_ff     <= sine_in;
      ease_val_ff <= ease_val_in;
      prod_ff     <= prod_in;
      pos_x_ff    <= pos_x_in;
      leftover_ff <= leftover_in;
      finished_ff <= finished_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // finished exactly when the step used up the remaining time
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[49] == !rsp_tdata[48]))
      else $error("finished flag disagrees with leftover sign");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != emi_pkg::S_IDLE) |-> (elapsed_ff <= dur_t))
      else $error("elapsed time beyond duration");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == emi_pkg::S_PHASE) |-> (quo_ff <= emi_pkg::Q16_ONE))
      else $error("progress above one");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == emi_pkg::S_MUL_X) |-> (ease_val_ff <= emi_pkg::Q16_ONE))
      else $error("ease value above one");
`endif

endmodule

`default_nettype wire

@@ dv/eased_motion_interpolator_tb.sv @@
// ----------------------------------------------------------------------------
// eased_motion_interpolator_tb: self-checking bench for the eased motion block
// Ticks are queued per register setting and driven on the req stream with
// random gaps. Each accepted tick is run through a local model of the elapsed
// clock, divider, ease curves and interpolation. Every rsp item is compared
// field by field against the oldest predicted point. Settings change only
// while the block is idle. The run covers extreme coordinates, every ease
// curve, zero and shrinking durations, overshoot and ignored register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module eased_motion_interpolator_tb;

   localparam int          ITEM_TARGET   = 950;
   localparam int          SETTLE_CYCLES = 30;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          Q16_UNIT      = 65536;
   localparam logic [2:0]  REG_SPARE_LO  = 3'd6;
   localparam logic [2:0]  REG_SPARE_HI  = 3'd7;
   localparam longint unsigned SINE_POLY [0:6] = '{
      64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
      64'd172272, 64'd3864, 64'd61
   };

   typedef struct packed {
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [16:0] leftover_ms;
      logic        finished;
   } motion_point_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // delta_ms[15:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // pos_x[15:0], pos_y[31:16], leftover_ms[48:32],
                                   // finished[49], zero
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_addr   = '0;
   logic [15:0] csr_wdata  = '0;

   // local copy of the block's registers and elapsed clock
   logic [15:0]            cfg_duration = emi_pkg::DURATION_RESET;
   logic signed [15:0]     cfg_start_x  = '0;
   logic signed [15:0]     cfg_start_y  = '0;
   logic signed [15:0]     cfg_end_x    = '0;
   logic signed [15:0]     cfg_end_y    = '0;
   emi_pkg::ease_mode_type cfg_mode     = emi_pkg::EASE_LINEAR;
   logic [15:0]            elapsed_ms   = '0;

   logic [15:0]      pending_deltas[$];
   motion_point_type expected_points[$];

   bit sender_gapless   = 1'b0;
   bit receiver_gapless = 1'b0;
   int hold_asked       = 0;
   int hold_done        = 0;
   int send_gap         = 0;
   int rsp_wait         = 0;
   int fail_count       = 0;
   int ticks_queued     = 0;
   int ticks_accepted   = 0;
   int points_checked   = 0;
   int finished_points  = 0;
   int overshoot_points = 0;
   int settings_applied = 0;
   int mode_ticks [4]   = '{0, 0, 0, 0};

   eased_motion_interpolator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // quarter-wave table entry, q16, from the odd q30 polynomial
   function automatic int sine_q16(int idx);
      longint unsigned u;
      longint unsigned u2;
      longint unsigned t;
      longint unsigned v;
      if (idx > emi_pkg::SINE_TABLE_ENTRIES) idx = emi_pkg::SINE_TABLE_ENTRIES;
      u  = (64'(idx) << 30) / 64'(emi_pkg::SINE_TABLE_ENTRIES);
      u2 = (u * u) >> 30;
      t  = SINE_POLY[6];
      for (int k = 5; k >= 0; k--) t = SINE_POLY[k] - ((t * u2) >> 30);
      v = (((t * u) >> 30) + 64'd8192) >> 14;
      return (v > 64'(Q16_UNIT)) ? Q16_UNIT : int'(v);
   endfunction

   function automatic int quarter_sine(int phase);
      if (phase > Q16_UNIT) phase = Q16_UNIT;
      return sine_q16((phase * emi_pkg::SINE_TABLE_ENTRIES + Q16_UNIT / 2) >> 16);
   endfunction

   function automatic int eased_progress(int p);
      case (cfg_mode)
         emi_pkg::EASE_SINE_IN:  return Q16_UNIT - quarter_sine(Q16_UNIT - p);
         emi_pkg::EASE_SINE_OUT: return quarter_sine(p);
         emi_pkg::EASE_SINE_IO: begin
            if (p <= Q16_UNIT / 2)
               return (Q16_UNIT - quarter_sine(Q16_UNIT - 2 * p) + 1) >> 1;
            else
               return (Q16_UNIT + quarter_sine(2 * p - Q16_UNIT) + 1) >> 1;
         end
         default:                return p;
      endcase
   endfunction

   function automatic logic [15:0] blend(logic signed [15:0] from, logic signed [15:0] to,
                                         int e);
      longint span;
      longint prod;
      span = longint'(to) - longint'(from);
      prod = span * longint'(e) + 64'sd32768;
      return 16'(longint'(from) + (prod >>> 16));
   endfunction

   // advances the elapsed clock by one tick and returns the point it lands on
   function automatic motion_point_type step_motion(logic [15:0] delta);
      motion_point_type pt;
      int               remaining;
      int               progress;
      int               e;
      if (elapsed_ms > cfg_duration) elapsed_ms = cfg_duration;
      remaining = int'(cfg_duration) - int'(elapsed_ms);
      if (int'(delta) <= remaining) elapsed_ms = elapsed_ms + delta;
      else elapsed_ms = cfg_duration;
      if (cfg_duration == 0) progress = Q16_UNIT;
      else progress = int'((64'(elapsed_ms) << 16) / 64'(cfg_duration));
      if (progress > Q16_UNIT) progress = Q16_UNIT;
      e = eased_progress(progress);
      pt.pos_x       = blend(cfg_start_x, cfg_end_x, e);
      pt.pos_y       = blend(cfg_start_y, cfg_end_y, e);
      pt.leftover_ms = 17'(int'(delta) - remaining);
      pt.finished    = (elapsed_ms == cfg_duration);
      return pt;
   endfunction

   // req driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_points.push_back(step_motion(req_tdata));
            ticks_accepted++;
            mode_ticks[cfg_mode]++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_deltas.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_deltas.pop_front();
               send_gap = sender_gapless ? 0 : $urandom_range(0, 11);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // rsp monitor and checker
   always @(posedge clock) begin : rsp_monitor
      motion_point_type seen;
      motion_point_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[48:32], rsp_tdata[49]};
            if (expected_points.size() == 0) begin
               $error("rsp item with no tick outstanding: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_points.pop_front();
               points_checked++;
               if (want.finished) finished_points++;
               if ($signed(want.leftover_ms) > 0) overshoot_points++;
               if (seen.pos_x !== want.pos_x) begin
                  $error("pos_x: expected %0d, got %0d",
                         $signed(want.pos_x), $signed(seen.pos_x));
                  fail_count++;
               end
               if (seen.pos_y !== want.pos_y) begin
                  $error("pos_y: expected %0d, got %0d",
                         $signed(want.pos_y), $signed(seen.pos_y));
                  fail_count++;
               end
               if (seen.leftover_ms !== want.leftover_ms) begin
                  $error("leftover_ms: expected %0d, got %0d",
                         $signed(want.leftover_ms), $signed(seen.leftover_ms));
                  fail_count++;
               end
               if (seen.finished !== want.finished) begin
                  $error("finished: expected %0d, got %0d", want.finished, seen.finished);
                  fail_count++;
               end
            end
            rsp_wait = receiver_gapless ? 0 : $urandom_range(0, 11);
         end
         if (hold_asked != hold_done) begin
            hold_done++;
            rsp_wait = HOLD_CYCLES;
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_deltas.size() != 0 || req_tvalid || expected_points.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [15:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      case (addr)
         emi_pkg::REG_DURATION: cfg_duration = data;
         emi_pkg::REG_START_X:  cfg_start_x  = data;
         emi_pkg::REG_START_Y:  cfg_start_y  = data;
         emi_pkg::REG_END_X:    cfg_end_x    = data;
         emi_pkg::REG_END_Y:    cfg_end_y    = data;
         emi_pkg::REG_EASE:     cfg_mode     = emi_pkg::ease_mode_type'(data[1:0]);
         default:               ;
      endcase
   endtask

   task automatic apply_settings(input logic [15:0] dur, input logic [15:0] sx,
                                 input logic [15:0] sy, input logic [15:0] ex,
                                 input logic [15:0] ey, input emi_pkg::ease_mode_type mode,
                                 input bit stray);
      wait_idle();
      csr_write(emi_pkg::REG_DURATION, dur);
      csr_write(emi_pkg::REG_START_X, sx);
      csr_write(emi_pkg::REG_START_Y, sy);
      csr_write(emi_pkg::REG_END_X, ex);
      csr_write(emi_pkg::REG_END_Y, ey);
      csr_write(emi_pkg::REG_EASE, 16'(mode));
      if (stray) begin
         csr_write(REG_SPARE_LO, 16'($urandom_range(0, 65535)));
         csr_write(REG_SPARE_HI, 16'($urandom_range(0, 65535)));
      end
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      settings_applied++;
   endtask

   task automatic queue_tick(input logic [15:0] delta);
      pending_deltas.push_back(delta);
      ticks_queued++;
   endtask

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin : stimulus
      int          n;
      int          stride;
      int          phase_no;
      logic [15:0] dur;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: linear over 1000 ms between zero points
      queue_tick(16'd0);
      queue_tick(16'd400);

      apply_settings(16'd1000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                     emi_pkg::EASE_LINEAR, 1'b1);
      queue_tick(16'd100);
      queue_tick(16'd500);
      queue_tick(16'hffff);

      // duration lowered below elapsed time
      apply_settings(16'd400, 16'd0, 16'hffff, 16'd16000, 16'd1,
                     emi_pkg::EASE_SINE_IN, 1'b0);
      queue_tick(16'd0);
      queue_tick(16'd5);

      // zero duration, also rewinds the elapsed clock
      apply_settings(16'd0, 16'd100, 16'd200, 16'hff9c, 16'hff38,
                     emi_pkg::EASE_SINE_OUT, 1'b0);
      queue_tick(16'd0);
      queue_tick(16'hffff);
      queue_tick(16'd7);

      // full-length motion across the in-out midpoint
      apply_settings(16'hffff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                     emi_pkg::EASE_SINE_IO, 1'b0);
      queue_tick(16'd16384);
      queue_tick(16'd16384);
      queue_tick(16'd1);
      queue_tick(16'd32766);
      queue_tick(16'hffff);

      apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, emi_pkg::EASE_LINEAR, 1'b0);
      queue_tick(16'd3);

      apply_settings(16'd2, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                     emi_pkg::EASE_SINE_OUT, 1'b0);
      repeat (3) queue_tick(16'd1);

      apply_settings(16'd3, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                     emi_pkg::EASE_SINE_IO, 1'b0);
      repeat (3) queue_tick(16'd1);

      phase_no = 0;
      while (ticks_queued < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0:          dur = 16'd0;
            1:          dur = 16'hffff;
            2, 3, 4:    dur = 16'($urandom_range(1, 32));
            5, 6, 7:    dur = 16'($urandom_range(33, 4000));
            default:    dur = 16'($urandom_range(1, 65535));
         endcase
         if ($urandom_range(0, 3) == 0) begin
            apply_settings(16'd0, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                           emi_pkg::ease_mode_type'($urandom_range(0, 3)), 1'b0);
            queue_tick(16'($urandom_range(0, 65535)));
         end
         apply_settings(dur, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                        emi_pkg::ease_mode_type'($urandom_range(0, 3)),
                        $urandom_range(0, 7) == 0);
         n                = $urandom_range(5, 40);
         sender_gapless   = ($urandom_range(0, 3) == 0);
         receiver_gapless = ($urandom_range(0, 3) == 0);
         if (phase_no == 2) begin
            // sender keeps offering while the receiver holds off
            n              = 30;
            sender_gapless = 1'b1;
            hold_asked++;
         end
         stride = (2 * int'(dur)) / n + 1;
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) queue_tick(16'($urandom_range(0, 65535)));
            else queue_tick(16'($urandom_range(0, stride)));
         end
         phase_no++;
      end

      wait_idle();
      $display("covered %0d ticks over %0d register settings", ticks_accepted,
               settings_applied);
      $display("linear %0d, in %0d, out %0d, in-out %0d; %0d points checked, %0d at the end, %0d overshoot",
               mode_ticks[emi_pkg::EASE_LINEAR], mode_ticks[emi_pkg::EASE_SINE_IN],
               mode_ticks[emi_pkg::EASE_SINE_OUT], mode_ticks[emi_pkg::EASE_SINE_IO],
               points_checked, finished_points, overshoot_points);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
